// File: hw/rtl/rave_pkg.sv
// Shared types and constants of the range active value count unit.
package rave_pkg;

  localparam int CNT_W = 11;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_COUNT  = 2'd1,
    CMD_TOGGLE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

// File: hw/rtl/range_active_value_count_unit.sv
// Load: a single table write; toggle: table read, then write-back of the inverted flag.
// Count query over n entries: one entry per cycle through the table read port, then the
// result sits in the output register; an empty range skips the scan.
// One command in flight; a new one is taken while a result waits in the output register.
// Reset clears control state only; table entries are undefined until loaded, and a load
// sets the entry's active flag, so no clearing pass is run.
module range_active_value_count_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [9:0]                    entry_index,
  input  logic signed [31:0]            item_value,
  input  logic [9:0]                    range_left,
  input  logic [9:0]                    range_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rave_pkg::CNT_W-1:0]    match_count
);
  import rave_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  res_t                  res;
  logic                  res_take;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [VALUE_BITS:0]   wr_data, rd_data;

  rave_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .entry_index (entry_index),
    .item_value  (item_value),
    .range_left  (range_left),
    .range_right (range_right),
    .res         (res),
    .res_take    (res_take),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  rave_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_BITS + 1)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_take = res.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      match_count <= res.count;
    end
  end

endmodule

// File: hw/rtl/rave_table.sv
// Entry table memory: one write port, one read port, registered read data.
module rave_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/rave_seq.sv
// Command sequencer: load, toggle read-modify-write and range scan over the table.
module rave_seq #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic [9:0]                       entry_index,
  input  logic signed [31:0]               item_value,
  input  logic [9:0]                       range_left,
  input  logic [9:0]                       range_right,
  output rave_pkg::res_t                   res,
  input  logic                             res_take,
  output logic                             wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
  output logic [VALUE_BITS:0]              wr_data,
  output logic                             rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  logic [VALUE_BITS:0]              rd_data
);
  import rave_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = ((AW > 10) ? AW : 10) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] MAX_IDX = CW'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_TOGGLE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic [AW-1:0]         last, last_next;
  logic [VALUE_BITS-1:0] key, key_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic                  issuing, issuing_next;

  logic [VALUE_BITS-1:0] val;
  logic [CW-1:0]         idx_x, left_x, right_raw, right_x;
  logic                  idx_ok, nonempty, match;
  logic [AW-1:0]         ptr_inc;

  assign val       = VALUE_BITS'($unsigned(item_value));
  assign idx_x     = CW'(entry_index);
  assign idx_ok    = idx_x < DEPTH_C;
  assign left_x    = CW'(range_left);
  assign right_raw = CW'(range_right);
  assign right_x   = (right_raw > MAX_IDX) ? MAX_IDX : right_raw;
  assign nonempty  = left_x <= right_x;
  assign ptr_inc   = ptr + 1'b1;
  assign match     = rd_data[VALUE_BITS] && (rd_data[VALUE_BITS-1:0] == key);

  assign in_ready  = (state == ST_IDLE);
  assign res.valid = (state == ST_DONE);
  assign res.count = cnt;

  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    last_next    = last;
    key_next     = key;
    cnt_next     = cnt;
    issuing_next = issuing;
    wr_en        = 1'b0;
    wr_addr      = AW'(idx_x);
    wr_data      = {1'b1, val};
    rd_en        = 1'b0;
    rd_addr      = AW'(left_x);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_LOAD: begin
              wr_en = idx_ok;
            end
            CMD_COUNT: begin
              key_next = val;
              cnt_next = '0;
              if (nonempty) begin
                rd_en        = 1'b1;
                ptr_next     = AW'(left_x);
                last_next    = AW'(right_x);
                issuing_next = (left_x != right_x);
                state_next   = ST_SCAN;
              end else begin
                state_next = ST_DONE;
              end
            end
            CMD_TOGGLE: begin
              if (idx_ok) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(idx_x);
                ptr_next   = AW'(idx_x);
                state_next = ST_TOGGLE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (match && (cnt != CNT_MAX)) begin
          cnt_next = cnt + 1'b1;
        end
        if (issuing) begin
          rd_en        = 1'b1;
          rd_addr      = ptr_inc;
          ptr_next     = ptr_inc;
          issuing_next = (ptr_inc != last);
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_TOGGLE: begin
        wr_en      = 1'b1;
        wr_addr    = ptr;
        wr_data    = {~rd_data[VALUE_BITS], rd_data[VALUE_BITS-1:0]};
        state_next = ST_IDLE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      issuing <= 1'b0;
    end else begin
      state   <= state_next;
      issuing <= issuing_next;
    end
    ptr  <= ptr_next;
    last <= last_next;
    key  <= key_next;
    cnt  <= cnt_next;
  end

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !issuing) |=> (state == ST_DONE))
    else $error("scan did not finish after last read");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (ptr <= last))
    else $error("scan pointer passed end of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("table read and write in the same cycle");

  a_toggle_back: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TOGGLE) |=> (state == ST_IDLE))
    else $error("toggle write-back did not return to idle");

endmodule
